FILE: design/ufd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ufd_pkg;

  // Result kinds carried on the master-side tuser
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_LEN_ERR = 2'd1,
    KIND_SUM_ERR = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  // Input item kinds carried on the slave-side tuser
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_RX_ENABLE = 2'd0;
  localparam logic [1:0] REG_MIN_LEN   = 2'd1;
  localparam logic [1:0] REG_MAX_LEN   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  // Header marker byte ('#')
  localparam logic [7:0] HEADER_CHAR = 8'h23;

  // Smallest length byte that is ever accepted, and the hard length cap
  localparam logic [5:0] LEN_FLOOR = 6'd3;
  localparam int         LEN_CAP   = 32;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int PLEN_W  = 5;
  localparam int TICK_W  = 16;
  localparam int HASH_W  = 3;
  localparam int IDX_W   = 6;

endpackage : ufd_pkg

`default_nettype wire

FILE: design/uart_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata                              tuser           tlast
// s_*       in   [7:0] rx_byte                      cmd (0 byte,    -
//                                                   1 tick)
// m_*       out  [7:0] data_byte, [12:8]            kind            last
//                payload_len, [15:13] zero
// cfg_*     in   write enable, 2-bit index, 16-bit data (no read-back)
//
// An input item is registered in S_IDLE and the frame state is updated in
// S_EXEC. An error result then goes through S_ERR to load the output register.
// A good frame is emitted from the frame store at one byte per cycle while
// m_tready does not stall it (one read port, registered read data); the input
// stays closed until its last byte loads. The output register stalls on m_tready
// without losing data. Reset is synchronous; the frame store is not cleared.

module uart_frame_deframer
  import ufd_pkg::*;
#(
  parameter int MAX_FRAME  = 32,
  parameter int HEADER_RUN = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] cmd
  // master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] data_byte, [12:8] payload_len, [15:13] zero
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int AW       = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int CW       = (AW > PLEN_W) ? AW : PLEN_W;
  localparam int HI_CAP   = (MAX_FRAME < LEN_CAP) ? MAX_FRAME : LEN_CAP;
  localparam int HASH_SAT = (HEADER_RUN < 7) ? HEADER_RUN + 1 : 7;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_READ} phase_t;
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ERR, S_EMIT} state_t;

  // configuration registers
  logic              rx_enable;
  logic [LEN_W-1:0]  min_frame_len;
  logic [LEN_W-1:0]  max_frame_len;
  logic [TICK_W-1:0] timeout_ticks;

  // sequencer and frame state
  state_t             state;
  phase_t             phase, phase_next;
  logic [HASH_W-1:0]  hash_run_count, hash_run_count_next;
  logic               header_pending, header_pending_next;
  logic [BYTE_W-1:0]  frame_length, frame_length_next;
  logic [IDX_W-1:0]   byte_index, byte_index_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [TICK_W-1:0]  deadline_count, deadline_count_next;
  logic               item_cmd;
  logic [BYTE_W-1:0]  item_byte;
  kind_t              err_kind, err_kind_next;
  logic               go_err, go_emit;
  logic [AW-1:0]      emit_idx;

  // frame store
  logic [BYTE_W-1:0]  frame_store [MAX_FRAME];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      rd_addr;
  logic [BYTE_W-1:0]  rd_q;

  // effective length limits
  logic [LEN_W-1:0]   len_lo, len_hi;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   slot;
  logic [TICK_W-1:0]  dl_dec;
  logic [PLEN_W-1:0]  plen;
  logic               out_free, emit_load, emit_last;
  phase_t             ph;

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign emit_load = (state == S_EMIT) && out_free;
  assign plen      = PLEN_W'(frame_length - 8'd2);
  assign emit_last = (CW'(emit_idx) + CW'(1)) == CW'(plen);

  assign len_lo = (min_frame_len < LEN_FLOOR) ? LEN_FLOOR : min_frame_len;
  assign len_hi = (max_frame_len > LEN_W'(HI_CAP)) ? LEN_W'(HI_CAP) : max_frame_len;

  assign idx_inc = byte_index + 1'b1;
  assign slot    = byte_index - 1'b1;
  assign dl_dec  = (deadline_count != '0) ? deadline_count - 1'b1 : deadline_count;

  // read address runs one ahead when a byte leaves, so rd_q follows emit_idx
  always_comb begin
    if (state == S_EMIT) begin
      rd_addr = emit_load ? AW'(emit_idx + 1'b1) : emit_idx;
    end else begin
      rd_addr = '0;
    end
  end

  // frame update for the item held in the execute step
  always_comb begin
    phase_next          = phase;
    hash_run_count_next = hash_run_count;
    header_pending_next = header_pending;
    frame_length_next   = frame_length;
    byte_index_next     = byte_index;
    running_sum_next    = running_sum;
    deadline_count_next = deadline_count;
    err_kind_next       = err_kind;
    go_err              = 1'b0;
    go_emit             = 1'b0;
    mem_we              = 1'b0;
    mem_waddr           = slot[AW-1:0];
    ph                  = (phase == PH_READ) ? PH_READ : PH_WAIT;

    if (state == S_EXEC) begin
      if (!rx_enable) begin
        phase_next          = PH_IDLE;
        hash_run_count_next = '0;
        header_pending_next = 1'b0;
      end else begin
        if (item_cmd == CMD_BYTE) begin
          // header run count, saturating
          if (item_byte == HEADER_CHAR) begin
            if (hash_run_count != HASH_W'(HASH_SAT)) begin
              hash_run_count_next = hash_run_count + 1'b1;
            end
            if ((hash_run_count_next == HASH_W'(HEADER_RUN)) &&
                (hash_run_count != HASH_W'(HEADER_RUN))) begin
              header_pending_next = 1'b1;
            end
          end else begin
            hash_run_count_next = '0;
          end

          if (ph == PH_READ) begin
            if (byte_index == '0) begin
              // length byte
              frame_length_next = item_byte;
              running_sum_next  = item_byte;
              byte_index_next   = IDX_W'(1);
              if ((item_byte < {2'b00, len_lo}) || (item_byte > {2'b00, len_hi})) begin
                err_kind_next = KIND_LEN_ERR;
                go_err        = 1'b1;
                ph            = PH_WAIT;
              end
            end else begin
              mem_we          = 1'b1;
              byte_index_next = idx_inc;
              if ({2'b00, idx_inc} == frame_length) begin
                // checksum byte
                ph = PH_WAIT;
                if (item_byte == running_sum) begin
                  go_emit = 1'b1;
                end else begin
                  err_kind_next = KIND_SUM_ERR;
                  go_err        = 1'b1;
                end
              end else begin
                running_sum_next = running_sum + item_byte;
              end
            end
          end
        end else if (ph == PH_READ) begin
          // timer tick counts the deadline down
          deadline_count_next = dl_dec;
          if (dl_dec == '0) begin
            err_kind_next = KIND_TIMEOUT;
            go_err        = 1'b1;
            ph            = PH_WAIT;
          end
        end

        // a pending header opens the next frame
        if ((ph == PH_WAIT) && header_pending_next) begin
          header_pending_next = 1'b0;
          hash_run_count_next = '0;
          ph                  = PH_READ;
          byte_index_next     = '0;
          running_sum_next    = '0;
          deadline_count_next = timeout_ticks;
        end
        phase_next = ph;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable     <= 1'b0;
      min_frame_len <= LEN_W'(3);
      max_frame_len <= LEN_W'(32);
      timeout_ticks <= TICK_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RX_ENABLE: rx_enable     <= cfg_wdata[0];
        REG_MIN_LEN:   min_frame_len <= cfg_wdata[LEN_W-1:0];
        REG_MAX_LEN:   max_frame_len <= cfg_wdata[LEN_W-1:0];
        REG_TIMEOUT:   timeout_ticks <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= item_byte;
    end
    rd_q <= frame_store[rd_addr];
  end

  // sequencer, frame state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_IDLE;
      hash_run_count <= '0;
      header_pending <= 1'b0;
      frame_length   <= '0;
      byte_index     <= '0;
      running_sum    <= '0;
      deadline_count <= '0;
      err_kind       <= KIND_DATA;
      emit_idx       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      phase          <= phase_next;
      hash_run_count <= hash_run_count_next;
      header_pending <= header_pending_next;
      frame_length   <= frame_length_next;
      byte_index     <= byte_index_next;
      running_sum    <= running_sum_next;
      deadline_count <= deadline_count_next;
      err_kind       <= err_kind_next;

      // taken result leaves, unless a new one loads in the same cycle
      if (m_tvalid && m_tready && (state != S_ERR) && !emit_load) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            item_cmd  <= s_tuser;
            item_byte <= s_tdata;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          emit_idx <= '0;
          if (go_err) begin
            state <= S_ERR;
          end else if (go_emit) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ERR: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tuser  <= err_kind;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, plen, rd_q};
            m_tuser  <= KIND_DATA;
            m_tlast  <= emit_last;
            emit_idx <= AW'(emit_idx + 1'b1);
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : uart_frame_deframer

`default_nettype wire

FILE: verif/uart_frame_deframer_test.sv
`timescale 1ns / 1ps

module uart_frame_deframer_test;
  import ufd_pkg::*;

  localparam int HDR_RUN       = 5;
  localparam int HASH_SAT      = 6;
  localparam int RESET_TIMEOUT = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 300000;

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_READ} rx_phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] val;
  } rx_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [4:0] plen;
    logic       last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_tuser = CMD_BYTE; // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [7:0] data_byte, [12:8] payload_len, [15:13] zero
  logic [1:0]  m_tuser;           // [1:0] kind
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_RX_ENABLE;
  logic [15:0] cfg_wdata = 16'h0000;

  // Stimulus backlog and expected results
  rx_item_t      rx_backlog[$];
  frame_result_t expected_out[$];
  int            rx_pushed = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // Deframer shadow: register copies and frame state
  logic       en_q;
  logic [5:0] min_len_q;
  logic [5:0] max_len_q;
  logic [15:0] timeout_q;
  rx_phase_t  ph;
  logic [2:0] hash_run;
  logic       hdr_pending;
  logic [7:0] frame_len;
  logic [5:0] byte_idx;
  logic [7:0] byte_sum;
  logic [15:0] ticks_left;
  logic [7:0] frame_bytes [LEN_CAP];

  // Sender and receiver pacing
  int burst_left = 4;
  int gap_left   = 0;
  int calm_left  = 0;
  int stall_left = 0;

  uart_frame_deframer #(
    .MAX_FRAME (LEN_CAP),
    .HEADER_RUN(HDR_RUN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL uart_frame_deframer");
      $finish;
    end
  end

  // Error result ends the frame and drops back to waiting
  task automatic push_error(input kind_t k);
    frame_result_t r;
    r.kind = k;
    r.data = 8'h00;
    r.plen = 5'd0;
    r.last = 1'b1;
    expected_out.push_back(r);
    ph = ST_WAIT;
  endtask

  // Advance the shadow deframer by one accepted transaction
  task automatic deframe_step(input logic cmd, input logic [7:0] b);
    int            nc;
    int            lo;
    int            hi;
    int            plen;
    frame_result_t r;
    if (!en_q) begin
      ph          = ST_IDLE;
      hash_run    = '0;
      hdr_pending = 1'b0;
    end else begin
      if (ph == ST_IDLE) ph = ST_WAIT;
      if (cmd == CMD_BYTE) begin
        // '#' run counter, saturating one above the header length
        if (b == HEADER_CHAR) begin
          nc = hash_run + 1;
          if (nc > HASH_SAT) nc = HASH_SAT;
          if (nc == HDR_RUN && hash_run != HDR_RUN) hdr_pending = 1'b1;
          hash_run = nc[2:0];
        end else begin
          hash_run = '0;
        end
        if (ph == ST_READ) begin
          if (byte_idx == 0) begin
            // length byte, checked against the clamped limits
            lo = (min_len_q < LEN_FLOOR) ? LEN_FLOOR : min_len_q;
            hi = (max_len_q > LEN_CAP) ? LEN_CAP : max_len_q;
            frame_len = b;
            byte_sum  = b;
            byte_idx  = 6'd1;
            if (b < lo || b > hi) push_error(KIND_LEN_ERR);
          end else begin
            frame_bytes[byte_idx - 6'd1] = b;
            byte_idx = byte_idx + 6'd1;
            if (byte_idx == frame_len) begin
              // final byte is the checksum
              if (b == byte_sum) begin
                plen = frame_len - 2;
                for (int i = 0; i < plen; i++) begin
                  r.kind = KIND_DATA;
                  r.data = frame_bytes[i];
                  r.plen = 5'(plen);
                  r.last = (i == plen - 1);
                  expected_out.push_back(r);
                end
                ph = ST_WAIT;
              end else begin
                push_error(KIND_SUM_ERR);
              end
            end else begin
              byte_sum = byte_sum + b;
            end
          end
        end
      end else if (ph == ST_READ) begin
        if (ticks_left != 0) ticks_left = ticks_left - 16'd1;
        if (ticks_left == 0) push_error(KIND_TIMEOUT);
      end
      // a pending header opens the next frame straight away
      if (ph == ST_WAIT && hdr_pending) begin
        hdr_pending = 1'b0;
        hash_run    = '0;
        ph          = ST_READ;
        byte_idx    = '0;
        byte_sum    = '0;
        ticks_left  = timeout_q;
      end
    end
  endtask

  // Monitor: register writes, accepted input, result check
  always @(posedge clk) begin : watch
    frame_result_t want;
    if (rst) begin
      en_q        = 1'b0;
      min_len_q   = LEN_FLOOR;
      max_len_q   = 6'(LEN_CAP);
      timeout_q   = 16'(RESET_TIMEOUT);
      ph          = ST_IDLE;
      hash_run    = '0;
      hdr_pending = 1'b0;
      frame_len   = '0;
      byte_idx    = '0;
      byte_sum    = '0;
      ticks_left  = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RX_ENABLE: en_q      = cfg_wdata[0];
          REG_MIN_LEN:   min_len_q = cfg_wdata[5:0];
          REG_MAX_LEN:   max_len_q = cfg_wdata[5:0];
          REG_TIMEOUT:   timeout_q = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) deframe_step(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %02h len %0d last %0b",
                   $time, m_tuser, m_tdata[7:0], m_tdata[12:8], m_tlast);
          mismatch_count++;
        end else begin
          want = expected_out.pop_front();
          if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
              m_tdata[12:8] !== want.plen || m_tlast !== want.last ||
              m_tdata[15:13] !== 3'b000) begin
            $display("%0t: expected kind %0d byte %02h len %0d last %0b, got kind %0d tdata %04h last %0b",
                     $time, want.kind, want.data, want.plen, want.last,
                     m_tuser, m_tdata, m_tlast);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Sender: bursts of transactions with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        rx_backlog.delete(0);
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (gap_left != 0 || rx_backlog.size() == 0) begin
        if (gap_left != 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tuser  <= rx_backlog[0].cmd;
        s_tdata  <= rx_backlog[0].val;
      end
    end
  end

  // Receiver: calm stretches, short stalls and random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (calm_left != 0) begin
      calm_left--;
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 15))
        0: begin
          calm_left = $urandom_range(16, 64);
          m_tready <= 1'b1;
        end
        1, 2: begin
          stall_left = $urandom_range(1, 5);
          m_tready <= 1'b0;
        end
        default: m_tready <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    rx_item_t it;
    it.cmd = CMD_BYTE;
    it.val = b;
    rx_backlog.push_back(it);
    rx_pushed++;
  endtask

  // Ticks carry random data, which the block should disregard
  task automatic add_tick();
    rx_item_t it;
    it.cmd = CMD_TICK;
    it.val = 8'($urandom_range(0, 255));
    rx_backlog.push_back(it);
    rx_pushed++;
  endtask

  // Header, length, payload and checksum; some payloads are heavy in '#'
  task automatic add_frame(input int len, input bit good_sum, input int tick_pct);
    logic [7:0] sum;
    logic [7:0] pb;
    int         hash_pct;
    hash_pct = ($urandom_range(0, 7) == 0) ? 40 : 0;
    repeat (HDR_RUN) add_byte(HEADER_CHAR);
    sum = 8'(len);
    add_byte(sum);
    repeat (len - 2) begin
      pb = ($urandom_range(0, 99) < hash_pct) ? HEADER_CHAR : 8'($urandom_range(0, 255));
      add_byte(pb);
      sum = sum + pb;
      if ($urandom_range(0, 99) < tick_pct) add_tick();
    end
    add_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  // Mostly well-formed frames, the rest broken frames and line noise
  task automatic run_traffic(input int n_items, input int lo, input int hi, input int tick_pct);
    int start;
    int pick;
    int len;
    start = rx_pushed;
    while (rx_pushed - start < n_items) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(lo, (hi < lo + 6) ? hi : lo + 6);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(lo, hi);
      if ($urandom_range(0, 24) == 0) len = hi;
      if (pick < 65 || (pick >= 91 && tick_pct < 20)) begin
        add_frame(len, 1'b1, tick_pct);
      end else if (pick < 75) begin
        add_frame(len, 1'b0, tick_pct);
      end else if (pick < 83) begin
        // length byte outside any legal range
        repeat (HDR_RUN) add_byte(HEADER_CHAR);
        add_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2))
                                             : 8'($urandom_range(LEN_CAP + 1, 255)));
      end else if (pick < 91) begin
        // noise, sometimes a run of '#' of any length
        if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 8)) add_byte(HEADER_CHAR);
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0) add_tick();
          else add_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        // frame cut short, then ticks to run the deadline down
        repeat (HDR_RUN) add_byte(HEADER_CHAR);
        add_byte(8'(len));
        repeat ($urandom_range(0, len - 3)) add_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 8)) add_tick();
      end
    end
  endtask

  // Hold off until everything sent has been answered, then let the block settle
  task automatic wait_quiet();
    while (rx_backlog.size() != 0 || expected_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_RX_ENABLE, 16'd1);
    write_reg(REG_MIN_LEN, 16'd3);
    write_reg(REG_MAX_LEN, 16'd32);
    write_reg(REG_TIMEOUT, 16'd1);

    // tick while waiting is ignored
    add_tick();
    // shortest good frame, payload 0xFF
    repeat (HDR_RUN) add_byte(HEADER_CHAR);
    add_byte(8'd3);
    add_byte(8'hFF);
    add_byte(8'h02);
    // length byte far too large
    repeat (HDR_RUN) add_byte(HEADER_CHAR);
    add_byte(8'hFF);
    // header found inside a frame, bad checksum, then the pending frame times out
    repeat (HDR_RUN) add_byte(HEADER_CHAR);
    add_byte(8'd8);
    repeat (HDR_RUN) add_byte(HEADER_CHAR);
    add_byte(8'h00);
    add_byte(8'h55);
    add_tick();
    wait_quiet();

    write_reg(REG_TIMEOUT, 16'hFFFF);
    run_traffic(90, 3, 32, 0);
    wait_quiet();

    // leave a frame open, then disable: it is dropped without a result
    repeat (HDR_RUN) add_byte(HEADER_CHAR);
    add_byte(8'd12);
    repeat (4) add_byte(8'($urandom_range(0, 255)));
    wait_quiet();
    write_reg(REG_RX_ENABLE, 16'd0);
    repeat (HDR_RUN) add_byte(HEADER_CHAR);
    add_tick();
    add_byte(8'h41);
    wait_quiet();
    write_reg(REG_RX_ENABLE, 16'd1);
    write_reg(REG_TIMEOUT, 16'(RESET_TIMEOUT));
    run_traffic(40, 3, 32, 5);
    wait_quiet();

    // lower limit above upper: every length fails
    write_reg(REG_MIN_LEN, 16'd32);
    write_reg(REG_MAX_LEN, 16'd3);
    run_traffic(25, 3, 32, 0);
    wait_quiet();

    // narrow window, short deadline, plenty of ticks
    write_reg(REG_MIN_LEN, 16'd8);
    write_reg(REG_MAX_LEN, 16'd16);
    write_reg(REG_TIMEOUT, 16'd6);
    run_traffic(50, 8, 16, 25);
    wait_quiet();

    write_reg(REG_MIN_LEN, 16'd3);
    write_reg(REG_MAX_LEN, 16'd32);
    write_reg(REG_TIMEOUT, 16'(RESET_TIMEOUT));
    run_traffic(40, 3, 32, 3);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("PASS uart_frame_deframer");
    end else begin
      $display("FAIL uart_frame_deframer");
    end
    $finish;
  end

endmodule
